[rtl/rbst_pkg.sv]
// shared types for the ray box slab test
package rbst_pkg;

    // per-axis status that travels beside the slab distances
    typedef struct packed {
        logic parallel;  // direction component is zero
        logic outside;   // origin lies outside the slab on this axis
    } lane_flags_t;

endpackage

[rtl/ray_box_slab_test_top.sv]
// top level of the ray versus axis-aligned box slab test
// Usage:
//   s_ channel: one word per test, twelve signed fixed-point coordinates
//   (origin xyz, direction xyz, box min xyz, box max xyz).
//   m_ channel: one word per test, hit flag and hit distance.
//   Three axis lanes each run two pipelined dividers that produce one
//   quotient bit per stage; the divider depth sets the latency.
//   Throughput: one word per cycle, every cycle, while m_tready is high.
//   Reset clears all valid flags; data registers are not reset.
//   When the receiver stalls, the whole pipeline still advances while
//   its last stage is empty; once the last stage holds a word, the
//   pipeline freezes and s_tready drops until the waiting result
//   is taken.
//   A zero direction component marks a parallel axis; quotients
//   saturate to the coordinate range; a miss reports distance 0.
module ray_box_slab_test_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hit, hit_distance
    output logic [((COORD_WIDTH+1+7)/8)*8-1:0] m_tdata
);
    localparam int W    = COORD_WIDTH;
    localparam int TOT  = W + FRAC_BITS + 7;
    localparam int OUTW = ((W + 1 + 7) / 8) * 8;

    logic [TOT-1:0] vld_reg;
    logic [TOT-1:0] vld_next;
    logic           ce;
    logic signed [W-1:0] t_near [3];
    logic signed [W-1:0] t_far  [3];
    rbst_pkg::lane_flags_t flags [3];
    logic                hit;
    logic signed [W-1:0] hit_dist;

    // advance unless a result waits and the last stage is occupied
    assign ce       = !vld_reg[TOT-1] || m_tready || !m_tvalid;
    assign s_tready = ce;

    // valid pipe
    assign vld_next = ce ? {vld_reg[TOT-2:0], s_tvalid} : vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // axis lanes
    for (genvar a = 0; a < 3; a++) begin : g_lane
        rbst_lane #(.W(W), .F(FRAC_BITS)) u_lane (
            .aclk   (aclk),
            .ce     (ce),
            .o      (s_tdata[a*W +: W]),
            .d      (s_tdata[(3+a)*W +: W]),
            .lo     (s_tdata[(6+a)*W +: W]),
            .hi     (s_tdata[(9+a)*W +: W]),
            .t_near (t_near[a]),
            .t_far  (t_far[a]),
            .flags  (flags[a])
        );
    end

    rbst_merge #(.W(W)) u_merge (
        .aclk     (aclk),
        .ce       (ce),
        .t_near   (t_near),
        .t_far    (t_far),
        .flags    (flags),
        .hit      (hit),
        .hit_dist (hit_dist)
    );

    assign m_tvalid = vld_reg[TOT-1];
    assign m_tdata  = OUTW'({hit_dist, hit});

endmodule

[rtl/rbst_div.sv]
// pipelined signed fixed-point divider, one quotient bit per stage, saturating
module rbst_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                aclk,
    input  logic                ce,
    input  logic signed [W:0]   num,
    input  logic signed [W-1:0] den,
    output logic signed [W-1:0] q
);
    // dividend magnitude is W+1 bits, shifted left by F
    localparam int QW = W + F + 1;
    localparam logic [QW-1:0] LIM  = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [QW-1:0] LIM1 = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    logic [W-1:0]  rem_reg [0:QW];
    logic [QW-1:0] n_reg   [0:QW];
    logic [QW-1:0] qt_reg  [0:QW];
    logic [W-1:0]  d_reg   [0:QW];
    logic          neg_reg [0:QW];
    logic signed [W-1:0] q_reg;

    logic [W:0]   num_abs;
    logic [W-1:0] den_abs;

    // magnitudes of the operands
    assign num_abs = num[W] ? (W+1)'(-num) : num;
    assign den_abs = den[W-1] ? W'(-den) : den;

    // load stage
    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= '0;
            n_reg[0]   <= {num_abs, {F{1'b0}}};
            qt_reg[0]  <= '0;
            d_reg[0]   <= den_abs;
            neg_reg[0] <= num[W] ^ den[W-1];
        end
    end

    // restoring division stages
    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [W:0] trial;
        logic       qbit;
        assign trial = {rem_reg[i], n_reg[i][QW-1]};
        assign qbit  = (trial >= {1'b0, d_reg[i]});
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i+1] <= qbit ? W'(trial - {1'b0, d_reg[i]}) : trial[W-1:0];
                n_reg[i+1]   <= {n_reg[i][QW-2:0], 1'b0};
                qt_reg[i+1]  <= {qt_reg[i][QW-2:0], qbit};
                d_reg[i+1]   <= d_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // sign and saturation
    always_ff @(posedge aclk) begin
        if (ce) begin
            if (neg_reg[QW]) begin
                if (qt_reg[QW] > LIM1) begin
                    q_reg <= {1'b1, {(W-1){1'b0}}};
                end else begin
                    q_reg <= W'(-qt_reg[QW][W-1:0]);
                end
            end else begin
                if (qt_reg[QW] > LIM) begin
                    q_reg <= {1'b0, {(W-1){1'b1}}};
                end else begin
                    q_reg <= qt_reg[QW][W-1:0];
                end
            end
        end
    end

    assign q = q_reg;

endmodule

[rtl/rbst_lane.sv]
// one axis of the slab test: differences, two dividers, ordering
module rbst_lane #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                  aclk,
    input  logic                  ce,
    input  logic signed [W-1:0]   o,
    input  logic signed [W-1:0]   d,
    input  logic signed [W-1:0]   lo,
    input  logic signed [W-1:0]   hi,
    output logic signed [W-1:0]   t_near,
    output logic signed [W-1:0]   t_far,
    output rbst_pkg::lane_flags_t flags
);
    localparam int DL = W + F + 3;

    logic signed [W:0]   dlo_reg;
    logic signed [W:0]   dhi_reg;
    logic signed [W-1:0] d_reg;
    rbst_pkg::lane_flags_t flg_reg [0:DL];
    logic signed [W-1:0] t1;
    logic signed [W-1:0] t2;
    logic signed [W-1:0] near_reg;
    logic signed [W-1:0] far_reg;
    rbst_pkg::lane_flags_t out_flg_reg;

    // corner minus origin at full width, parallel and slab checks
    always_ff @(posedge aclk) begin
        if (ce) begin
            dlo_reg <= (W+1)'(lo) - (W+1)'(o);
            dhi_reg <= (W+1)'(hi) - (W+1)'(o);
            d_reg   <= d;
            flg_reg[0].parallel <= (d == '0);
            flg_reg[0].outside  <= (o < lo) || (o > hi);
        end
    end

    rbst_div #(.W(W), .F(F)) u_div_lo (
        .aclk(aclk), .ce(ce), .num(dlo_reg), .den(d_reg), .q(t1)
    );
    rbst_div #(.W(W), .F(F)) u_div_hi (
        .aclk(aclk), .ce(ce), .num(dhi_reg), .den(d_reg), .q(t2)
    );

    // flags ride along with the dividers
    for (genvar i = 0; i < DL; i++) begin : g_flg
        always_ff @(posedge aclk) begin
            if (ce) begin
                flg_reg[i+1] <= flg_reg[i];
            end
        end
    end

    // ascending order of the two distances
    always_ff @(posedge aclk) begin
        if (ce) begin
            near_reg    <= (t1 > t2) ? t2 : t1;
            far_reg     <= (t1 > t2) ? t1 : t2;
            out_flg_reg <= flg_reg[DL];
        end
    end

    assign t_near = near_reg;
    assign t_far  = far_reg;
    assign flags  = out_flg_reg;

endmodule

[rtl/rbst_merge.sv]
// merges the three axis results into hit and distance
module rbst_merge #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic                  ce,
    input  logic signed [W-1:0]   t_near [3],
    input  logic signed [W-1:0]   t_far  [3],
    input  rbst_pkg::lane_flags_t flags  [3],
    output logic                  hit,
    output logic signed [W-1:0]   hit_dist
);
    logic signed [W-1:0] tmin;
    logic signed [W-1:0] tmax;
    logic                out_any;
    logic signed [W-1:0] tmin_reg;
    logic signed [W-1:0] tmax_reg;
    logic                out_reg;
    logic                hit_reg;
    logic signed [W-1:0] dist_reg;

    // narrow the interval over the non-parallel axes, collect outside flags of parallel ones
    always_comb begin
        tmin    = {1'b1, {(W-1){1'b0}}};
        tmax    = {1'b0, {(W-1){1'b1}}};
        out_any = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (flags[a].parallel) begin
                out_any = out_any | flags[a].outside;
            end else begin
                if (t_near[a] > tmin) tmin = t_near[a];
                if (t_far[a] < tmax) tmax = t_far[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tmin_reg <= tmin;
            tmax_reg <= tmax;
            out_reg  <= out_any;
        end
    end

    // final decision
    always_ff @(posedge aclk) begin
        if (ce) begin
            if (out_reg || (tmin_reg > tmax_reg) || tmax_reg[W-1]) begin
                hit_reg  <= 1'b0;
                dist_reg <= '0;
            end else begin
                hit_reg  <= 1'b1;
                dist_reg <= tmin_reg[W-1] ? tmax_reg : tmin_reg;
            end
        end
    end

    assign hit      = hit_reg;
    assign hit_dist = dist_reg;

endmodule
